// ===== rtl/hbk_pkg.sv =====
// Package for the boot keyboard report translator: slot count, lock key and LED codes,
// the US layout tables and the decoded report type. No dependencies.
package hbk_pkg;

  localparam int KeySlots = 6;
  localparam int SlotW = (KeySlots > 1) ? $clog2(KeySlots) : 1;
  localparam int CountW = $clog2(KeySlots + 1);

  localparam logic [7:0] UsageCaps = 8'h39;
  localparam logic [7:0] UsageScroll = 8'h47;
  localparam logic [7:0] UsageNum = 8'h53;
  localparam logic [2:0] LedNum = 3'h1;
  localparam logic [2:0] LedCaps = 3'h2;
  localparam logic [2:0] LedScroll = 3'h4;
  localparam logic [7:0] ModShift = 8'h22;
  localparam logic [7:0] ModCtrl = 8'h11;
  localparam logic [7:0] TableLen = 8'd57;
  localparam logic [7:0] CaseOffset = 8'd32;

  typedef struct packed {
    logic [KeySlots-1:0][6:0] chars;
    logic [CountW-1:0] count;
    logic [2:0] leds;
    logic changed;
  } decode_t;

  function automatic logic [7:0] plain_map(input logic [7:0] key);
    logic [7:0] ch;
    ch = 8'h00;
    if (key >= 8'd4 && key <= 8'd29) begin
      ch = 8'(key + 8'h5D);
    end else if (key >= 8'd30 && key <= 8'd38) begin
      ch = 8'(key + 8'h13);
    end else begin
      case (key)
        8'd39: ch = 8'h30;
        8'd40: ch = 8'h0A;
        8'd41: ch = 8'h1B;
        8'd42: ch = 8'h08;
        8'd43: ch = 8'h09;
        8'd44: ch = 8'h20;
        8'd45: ch = 8'h2D;
        8'd46: ch = 8'h3D;
        8'd47: ch = 8'h5B;
        8'd48: ch = 8'h5D;
        8'd49: ch = 8'h5C;
        8'd51: ch = 8'h3B;
        8'd52: ch = 8'h27;
        8'd53: ch = 8'h60;
        8'd54: ch = 8'h2C;
        8'd55: ch = 8'h2E;
        8'd56: ch = 8'h2F;
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

  function automatic logic [7:0] shifted_map(input logic [7:0] key);
    logic [7:0] ch;
    ch = 8'h00;
    if (key >= 8'd4 && key <= 8'd29) begin
      ch = 8'(key + 8'h3D);
    end else begin
      case (key)
        8'd30: ch = 8'h21;
        8'd31: ch = 8'h40;
        8'd32: ch = 8'h23;
        8'd33: ch = 8'h24;
        8'd34: ch = 8'h25;
        8'd35: ch = 8'h5E;
        8'd36: ch = 8'h26;
        8'd37: ch = 8'h2A;
        8'd38: ch = 8'h28;
        8'd39: ch = 8'h29;
        8'd40: ch = 8'h0A;
        8'd41: ch = 8'h1B;
        8'd42: ch = 8'h08;
        8'd43: ch = 8'h09;
        8'd44: ch = 8'h20;
        8'd45: ch = 8'h5F;
        8'd46: ch = 8'h2B;
        8'd47: ch = 8'h7B;
        8'd48: ch = 8'h7D;
        8'd49: ch = 8'h7C;
        8'd51: ch = 8'h3A;
        8'd52: ch = 8'h22;
        8'd53: ch = 8'h7E;
        8'd54: ch = 8'h3C;
        8'd55: ch = 8'h3E;
        8'd56: ch = 8'h3F;
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

  function automatic logic [6:0] translate(input logic [7:0] key, input logic shift,
                                           input logic caps, input logic ctrl);
    logic [7:0] ch;
    logic lower;
    logic upper;
    ch = 8'h00;
    if (key < TableLen) begin
      ch = shift ? shifted_map(key) : plain_map(key);
    end
    lower = (ch >= 8'h61) && (ch <= 8'h7A);
    upper = (ch >= 8'h41) && (ch <= 8'h5A);
    if (caps && lower) begin
      ch = 8'(ch - CaseOffset);
    end else if (caps && upper) begin
      ch = 8'(ch + CaseOffset);
    end
    lower = (ch >= 8'h61) && (ch <= 8'h7A);
    upper = (ch >= 8'h41) && (ch <= 8'h5A);
    if (ctrl && lower) begin
      ch = 8'(ch - 8'h60);
    end else if (ctrl && upper) begin
      ch = 8'(ch - 8'h40);
    end
    return ch[6:0];
  endfunction

endpackage

// ===== rtl/hid_boot_keyboard_to_ascii_core.sv =====
// Top level of the boot keyboard report translator: input register, report decode and a
// result buffer emitting one character per unstalled cycle. Uses hbk_pkg, hbk_report_decode.
//
// The input channel (in_valid_i, in_stall_o) carries one boot keyboard report per
// transaction: the modifier byte and six key codes. The output channel (out_valid_o,
// out_stall_i) carries one result per transaction; last_of_report_o marks the final result
// of a report. A report that yields no character gives a single result with char_valid_o low.
// An accepted report is held in the input register, is decoded combinationally against the
// previous report and the lock LED state, and its results are loaded into the registered
// result buffer, which drives out_valid_o and the outputs; the load waits while the buffer
// still holds results of the previous report that the receiver has not taken.
// A report with n characters gives max(n, 1) results, one result per cycle unless stalled,
// shifted out of the result buffer one character per transaction. The next report
// is accepted into the input register while results are still being delivered and is
// loaded into the result buffer as the last result of the current report is taken.
// When the receiver stalls, the current result holds and, once the input register is full,
// in_stall_o rises. Reset clears the previous key codes, the LED state and all valid flags.
module hid_boot_keyboard_to_ascii_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] modifier_bits_i,
  input  logic [7:0] key_code_0_i,
  input  logic [7:0] key_code_1_i,
  input  logic [7:0] key_code_2_i,
  input  logic [7:0] key_code_3_i,
  input  logic [7:0] key_code_4_i,
  input  logic [7:0] key_code_5_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       char_valid_o,
  output logic [6:0] ascii_char_o,
  output logic [2:0] lock_leds_o,
  output logic       leds_changed_o,
  output logic       last_of_report_o
);

  logic [5:0][7:0] in_keys;
  logic in_accept;
  logic a_valid_q, a_valid_d;
  logic [7:0] a_mods_q;
  logic [hbk_pkg::KeySlots-1:0][7:0] a_keys_q;
  logic [hbk_pkg::KeySlots-1:0][7:0] prev_keys_q;
  logic [2:0] leds_q;
  hbk_pkg::decode_t dec;
  logic out_valid_q, out_valid_d;
  logic [hbk_pkg::KeySlots-1:0][6:0] chars_q;
  logic [hbk_pkg::CountW-1:0] rem_q;
  logic nochar_q;
  logic changed_q;
  logic take;
  logic last;
  logic load;

  assign in_keys = {key_code_5_i, key_code_4_i, key_code_3_i,
                    key_code_2_i, key_code_1_i, key_code_0_i};

  assign last = (rem_q == hbk_pkg::CountW'(1));
  assign take = out_valid_q && !out_stall_i;
  assign load = a_valid_q && (!out_valid_q || (take && last));
  assign in_stall_o = a_valid_q && !load;
  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    a_valid_d = a_valid_q;
    if (in_accept) begin
      a_valid_d = 1'b1;
    end else if (load) begin
      a_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (take && last) begin
      out_valid_d = 1'b0;
    end
  end

  hbk_report_decode u_decode (
    .modifier_bits_i (a_mods_q),
    .keys_i          (a_keys_q),
    .prev_keys_i     (prev_keys_q),
    .leds_i          (leds_q),
    .dec_o           (dec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      prev_keys_q <= '0;
      leds_q <= 3'h0;
      rem_q <= '0;
    end else begin
      a_valid_q <= a_valid_d;
      out_valid_q <= out_valid_d;
      if (load) begin
        prev_keys_q <= a_keys_q;
        leds_q <= dec.leds;
        rem_q <= (dec.count == '0) ? hbk_pkg::CountW'(1) : dec.count;
      end else if (take && !last) begin
        rem_q <= hbk_pkg::CountW'(rem_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_mods_q <= modifier_bits_i;
      a_keys_q <= in_keys[hbk_pkg::KeySlots-1:0];
    end
    if (load) begin
      chars_q <= dec.chars;
      nochar_q <= (dec.count == '0);
      changed_q <= dec.changed;
    end else if (take) begin
      for (int k = 0; k < hbk_pkg::KeySlots - 1; k++) begin
        chars_q[k] <= chars_q[k+1];
      end
      chars_q[hbk_pkg::KeySlots-1] <= 7'h00;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_valid_o = !nochar_q;
  assign ascii_char_o = nochar_q ? 7'h00 : chars_q[0];
  assign lock_leds_o = leds_q;
  assign leds_changed_o = changed_q && last;
  assign last_of_report_o = last;

endmodule

// ===== rtl/hbk_report_decode.sv =====
// Combinational decode of one keyboard report against the previous report and LED state.
// Produces the packed character list, its count, the new LED state and a lock change flag. Uses hbk_pkg.
module hbk_report_decode (
  input  logic [7:0]                            modifier_bits_i,
  input  logic [hbk_pkg::KeySlots-1:0][7:0]     keys_i,
  input  logic [hbk_pkg::KeySlots-1:0][7:0]     prev_keys_i,
  input  logic [2:0]                            leds_i,
  output hbk_pkg::decode_t                      dec_o
);

  always_comb begin
    logic shift;
    logic ctrl;
    logic caps;
    logic held;
    logic [2:0] leds;
    logic changed;
    logic [hbk_pkg::CountW-1:0] pos;
    logic [hbk_pkg::KeySlots-1:0][6:0] chars;
    logic [6:0] ch;
    shift = (modifier_bits_i & hbk_pkg::ModShift) != 8'h00;
    ctrl = (modifier_bits_i & hbk_pkg::ModCtrl) != 8'h00;
    leds = leds_i;
    caps = (leds & hbk_pkg::LedCaps) != 3'h0;
    changed = 1'b0;
    pos = '0;
    chars = '0;
    for (int i = 0; i < hbk_pkg::KeySlots; i++) begin
      held = 1'b0;
      for (int j = 0; j < hbk_pkg::KeySlots; j++) begin
        if (prev_keys_i[j] == keys_i[i]) begin
          held = 1'b1;
        end
      end
      ch = hbk_pkg::translate(keys_i[i], shift, caps, ctrl);
      if (keys_i[i] != 8'h00 && !held) begin
        if (keys_i[i] == hbk_pkg::UsageCaps) begin
          leds = leds ^ hbk_pkg::LedCaps;
          changed = 1'b1;
          caps = (leds & hbk_pkg::LedCaps) != 3'h0;
        end else if (keys_i[i] == hbk_pkg::UsageNum) begin
          leds = leds ^ hbk_pkg::LedNum;
          changed = 1'b1;
        end else if (keys_i[i] == hbk_pkg::UsageScroll) begin
          leds = leds ^ hbk_pkg::LedScroll;
          changed = 1'b1;
        end else if (ch != 7'h00) begin
          chars[pos[hbk_pkg::SlotW-1:0]] = ch;
          pos = hbk_pkg::CountW'(pos + 1'b1);
        end
      end
    end
    dec_o.chars = chars;
    dec_o.count = pos;
    dec_o.leds = leds;
    dec_o.changed = changed;
  end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for hid_boot_keyboard_to_ascii_core: a report driver, a result
// monitor and a keystroke predictor that tracks held keys and the lock LEDs.
// Depends on hbk_pkg and the core RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClockPeriod = 12;
  localparam int RandomReports = 430;
  localparam int CalmTail = 60;
  localparam int LongHold = 80;
  localparam int QuietLimit = 2000;

  typedef struct packed {
    logic [7:0] mods;
    logic [hbk_pkg::KeySlots-1:0][7:0] codes;
  } report_t;

  typedef struct {
    report_t rpt;
    bit after_drain;
  } stimulus_t;

  typedef struct packed {
    logic char_valid;
    logic [6:0] ascii;
    logic [2:0] leds;
    logic changed;
    logic last;
  } keystroke_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic char_valid_o;
  logic [6:0] ascii_char_o;
  logic [2:0] lock_leds_o;
  logic leds_changed_o;
  logic last_of_report_o;
  report_t offered = '0;

  stimulus_t pending_reports[$];
  keystroke_t awaited_keystrokes[$];
  logic [hbk_pkg::KeySlots-1:0][7:0] held_codes = '0;
  logic [2:0] lock_state = '0;

  int total_reports = 0;
  int quiet_after = 0;
  int reports_accepted = 0;
  int keystrokes_seen = 0;
  int chars_predicted = 0;
  int lock_toggles = 0;
  int errors = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  bit long_hold_done = 1'b0;
  logic calm;

  assign calm = (reports_accepted >= quiet_after);

  hid_boot_keyboard_to_ascii_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .modifier_bits_i (offered.mods),
    .key_code_0_i    (offered.codes[0]),
    .key_code_1_i    (offered.codes[1]),
    .key_code_2_i    (offered.codes[2]),
    .key_code_3_i    (offered.codes[3]),
    .key_code_4_i    (offered.codes[4]),
    .key_code_5_i    (offered.codes[5]),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .char_valid_o    (char_valid_o),
    .ascii_char_o    (ascii_char_o),
    .lock_leds_o     (lock_leds_o),
    .leds_changed_o  (leds_changed_o),
    .last_of_report_o(last_of_report_o)
  );

  always #(ClockPeriod / 2) clk_i = ~clk_i;

  function automatic logic [6:0] us_key_char(input logic [7:0] code, input logic shift,
                                             input logic caps, input logic ctrl);
    byte unsigned c;
    string row;
    c = 0;
    if (code >= 8'd4 && code <= 8'd29) begin
      c = (shift ? "A" : "a") + code - 8'd4;
    end else if (code >= 8'd30 && code <= 8'd39) begin
      row = shift ? "!@#$%^&*()" : "1234567890";
      c = row[code - 8'd30];
    end else if (code >= 8'd45 && code <= 8'd56 && code != 8'd50) begin
      row = shift ? "_+{}|?:\"~<>?" : "-=[]\\?;'`,./";
      c = row[code - 8'd45];
    end else begin
      case (code)
        8'd40: c = 8'h0A;
        8'd41: c = 8'h1B;
        8'd42: c = 8'h08;
        8'd43: c = 8'h09;
        8'd44: c = 8'h20;
        default: c = 0;
      endcase
    end
    if (caps && c >= "a" && c <= "z") begin
      c = c - 8'd32;
    end else if (caps && c >= "A" && c <= "Z") begin
      c = c + 8'd32;
    end
    if (ctrl && c >= "a" && c <= "z") begin
      c = c - "a" + 8'd1;
    end else if (ctrl && c >= "A" && c <= "Z") begin
      c = c - "A" + 8'd1;
    end
    return c[6:0];
  endfunction

  task automatic decode_report(input report_t rpt);
    logic [6:0] typed[$];
    logic [6:0] ch;
    logic [7:0] code;
    logic shift, ctrl, caps, changed, held;
    keystroke_t ks;
    int i, j;
    shift = |(rpt.mods & hbk_pkg::ModShift);
    ctrl = |(rpt.mods & hbk_pkg::ModCtrl);
    caps = |(lock_state & hbk_pkg::LedCaps);
    changed = 1'b0;
    for (i = 0; i < hbk_pkg::KeySlots; i++) begin
      code = rpt.codes[i];
      if (code == 8'd0) continue;
      held = 1'b0;
      for (j = 0; j < hbk_pkg::KeySlots; j++) begin
        if (held_codes[j] == code) held = 1'b1;
      end
      if (held) continue;
      if (code == hbk_pkg::UsageCaps) begin
        lock_state ^= hbk_pkg::LedCaps;
        caps = |(lock_state & hbk_pkg::LedCaps);
        changed = 1'b1;
        lock_toggles++;
      end else if (code == hbk_pkg::UsageNum) begin
        lock_state ^= hbk_pkg::LedNum;
        changed = 1'b1;
        lock_toggles++;
      end else if (code == hbk_pkg::UsageScroll) begin
        lock_state ^= hbk_pkg::LedScroll;
        changed = 1'b1;
        lock_toggles++;
      end else begin
        ch = us_key_char(code, shift, caps, ctrl);
        if (ch != 7'd0) typed.push_back(ch);
      end
    end
    held_codes = rpt.codes;
    chars_predicted += typed.size();
    if (typed.size() == 0) begin
      ks = '{char_valid: 1'b0, ascii: 7'd0, leds: lock_state, changed: changed, last: 1'b1};
      awaited_keystrokes.push_back(ks);
    end else begin
      for (i = 0; i < typed.size(); i++) begin
        ks.char_valid = 1'b1;
        ks.ascii = typed[i];
        ks.leds = lock_state;
        ks.last = (i == typed.size() - 1);
        ks.changed = ks.last && changed;
        awaited_keystrokes.push_back(ks);
      end
    end
  endtask

  task automatic report_mismatch(input string detail);
    errors++;
    $display("%0t ERROR %s", $realtime, detail);
  endtask

  function automatic void add_report(input logic [7:0] mods, input logic [7:0] c0,
                                     input logic [7:0] c1, input logic [7:0] c2,
                                     input logic [7:0] c3, input logic [7:0] c4,
                                     input logic [7:0] c5, input bit drain);
    stimulus_t stim;
    stim.rpt.mods = mods;
    stim.rpt.codes = {c5, c4, c3, c2, c1, c0};
    stim.after_drain = drain;
    pending_reports.push_back(stim);
  endfunction

  // Report driver: offers one report at a time and holds it until the core takes it.
  always @(posedge clk_i) begin : drive_reports
    logic next_valid;
    stimulus_t stim;
    next_valid = in_valid_i;
    if (!rst_ni) begin
      next_valid = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        decode_report(offered);
        reports_accepted++;
        next_valid = 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 7);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_reports.size() > 0 &&
                     !(pending_reports[0].after_drain && awaited_keystrokes.size() != 0)) begin
          stim = pending_reports.pop_front();
          offered <= stim.rpt;
          next_valid = 1'b1;
        end
      end
    end
    in_valid_i <= next_valid;
  end

  // Result monitor and receiver stall generator.
  always @(posedge clk_i) begin : check_keystrokes
    logic next_stall;
    keystroke_t want;
    next_stall = 1'b0;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        keystrokes_seen++;
        if (awaited_keystrokes.size() == 0) begin
          report_mismatch($sformatf("result with no report pending: char %0h last %0b",
                                    ascii_char_o, last_of_report_o));
        end else begin
          want = awaited_keystrokes.pop_front();
          if (char_valid_o !== want.char_valid)
            report_mismatch($sformatf("char_valid expected %0b got %0b",
                                      want.char_valid, char_valid_o));
          if (ascii_char_o !== want.ascii)
            report_mismatch($sformatf("ascii_char expected %02h got %02h",
                                      want.ascii, ascii_char_o));
          if (lock_leds_o !== want.leds)
            report_mismatch($sformatf("lock_leds expected %0d got %0d",
                                      want.leds, lock_leds_o));
          if (leds_changed_o !== want.changed)
            report_mismatch($sformatf("leds_changed expected %0b got %0b",
                                      want.changed, leds_changed_o));
          if (last_of_report_o !== want.last)
            report_mismatch($sformatf("last_of_report expected %0b got %0b",
                                      want.last, last_of_report_o));
        end
      end
      if (hold_left > 0) begin
        next_stall = 1'b1;
        hold_left--;
      end else if (!long_hold_done && reports_accepted >= 150) begin
        long_hold_done = 1'b1;
        hold_left = LongHold;
        next_stall = 1'b1;
      end else if (stall_left > 0) begin
        next_stall = 1'b1;
        stall_left--;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 6);
        next_stall = 1'b1;
      end
    end
    out_stall_i <= next_stall;
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t ERROR no transaction for %0d cycles", $realtime, QuietLimit);
        $display("hid_boot_keyboard_to_ascii_core: mismatch");
        $finish;
      end
    end
  end

  initial begin : run
    report_t rpt;
    logic [7:0] code;
    int n, s, kind, pick;

    // Directed reports; lock state and held keys carry from one to the next.
    add_report(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    add_report(8'h00, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    add_report(8'h00, 8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    add_report(8'h02, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 1'b0);
    add_report(8'h20, 8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 1'b0);
    add_report(8'h01, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 1'b0);
    add_report(8'h00, hbk_pkg::UsageCaps, 8'd4, 8'd30, 8'd0, 8'd0, 8'd0, 1'b0);
    add_report(8'h22, hbk_pkg::UsageCaps, 8'd5, 8'd36, 8'd0, 8'd0, 8'd0, 1'b0);
    add_report(8'h00, hbk_pkg::UsageNum, hbk_pkg::UsageScroll, 8'd0, 8'd0, 8'd0, 8'd0,
               1'b0);
    add_report(8'hFF, 8'h80, 8'hFF, 8'hC5, 8'h90, 8'hA0, 8'hFE, 1'b0);
    add_report(8'h00, 8'd50, 8'd58, 8'd1, 8'd2, 8'd3, 8'h7F, 1'b0);
    add_report(8'h00, 8'd7, 8'd7, 8'd7, 8'd0, 8'd0, 8'd0, 1'b0);
    add_report(8'h00, 8'd40, 8'd41, 8'd42, 8'd43, 8'd44, 8'd45, 1'b0);
    add_report(8'h02, 8'd46, 8'd47, 8'd48, 8'd49, 8'd50, 8'd51, 1'b0);
    add_report(8'h20, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd39, 1'b0);
    add_report(8'h33, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 1'b0);
    add_report(8'h00, 8'd8, hbk_pkg::UsageCaps, 8'd9, 8'd0, 8'd0, 8'd0, 1'b0);
    add_report(8'hFF, hbk_pkg::UsageNum, hbk_pkg::UsageScroll, hbk_pkg::UsageCaps,
               8'd0, 8'd0, 8'd0, 1'b0);
    add_report(8'hCC, 8'd22, 8'd23, 8'd24, 8'd25, 8'd26, 8'd27, 1'b0);
    add_report(8'h10, 8'd29, 8'd28, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    add_report(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);

    // Mostly typing sequences where keys stay held across reports, plus noise and releases.
    rpt = '0;
    for (n = 0; n < RandomReports; n++) begin
      kind = $urandom_range(0, 19);
      if (kind < 15) begin
        for (s = 0; s < hbk_pkg::KeySlots; s++) begin
          pick = $urandom_range(0, 9);
          if (pick >= 3 && pick < 6) begin
            rpt.codes[s] = 8'd0;
          end else if (pick >= 6) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) code = hbk_pkg::UsageCaps;
            else if (pick == 1) code = hbk_pkg::UsageNum;
            else if (pick == 2) code = hbk_pkg::UsageScroll;
            else if (pick <= 4) code = 8'($urandom_range(0, 255));
            else code = 8'($urandom_range(4, 56));
            rpt.codes[s] = code;
          end
        end
        case ($urandom_range(0, 4))
          0: rpt.mods = 8'h00;
          1: rpt.mods = hbk_pkg::ModShift & 8'($urandom_range(0, 255));
          2: rpt.mods = hbk_pkg::ModCtrl & 8'($urandom_range(0, 255));
          3: rpt.mods = (hbk_pkg::ModShift | hbk_pkg::ModCtrl) & 8'($urandom_range(0, 255));
          default: rpt.mods = 8'($urandom_range(0, 255));
        endcase
      end else if (kind < 18) begin
        rpt.mods = 8'($urandom_range(0, 255));
        for (s = 0; s < hbk_pkg::KeySlots; s++) rpt.codes[s] = 8'($urandom_range(0, 255));
      end else begin
        rpt.mods = 8'($urandom_range(0, 255));
        rpt.codes = '0;
      end
      add_report(rpt.mods, rpt.codes[0], rpt.codes[1], rpt.codes[2], rpt.codes[3],
                 rpt.codes[4], rpt.codes[5], (n == 0) || (n == 250));
    end
    total_reports = pending_reports.size();
    quiet_after = total_reports - CalmTail;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (reports_accepted != total_reports) @(posedge clk_i);
    while (awaited_keystrokes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d reports and %0d results, %0d of them characters.",
             reports_accepted, keystrokes_seen, chars_predicted);
    $display("Lock keys toggled %0d times; %0d errors found.", lock_toggles, errors);
    if (errors == 0) begin
      $display("hid_boot_keyboard_to_ascii_core: match");
    end else begin
      $display("hid_boot_keyboard_to_ascii_core: mismatch");
    end
    $finish;
  end

endmodule
